// ===== hdl/hnm_pkg.sv =====
// Package for the heightmap normal map block: widths, constants and the
// pipeline word types shared by every module. No dependencies.
package hnm_pkg;

    // Tile side; must be a power of two so that neighbour addresses wrap naturally.
    localparam int TILE_SIZE   = 64;
    localparam int COORD_W     = $clog2(TILE_SIZE);
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int CELLS       = TILE_SIZE * TILE_SIZE;
    localparam int HEIGHT_BITS = 16;

    // Magnitude of a neighbour difference fits in HEIGHT_BITS unsigned bits.
    localparam int MAG_W   = HEIGHT_BITS;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int Y_CONST = 512;
    localparam int Y_SQ    = Y_CONST * Y_CONST;
    localparam int V2_W    = (SQ_W > 19) ? SQ_W : 19;
    localparam int S_W     = (SQ_W + 2 > 20) ? SQ_W + 2 : 20;
    localparam int FULL_SQ = 255 * 255;
    localparam int FSQ_W   = 16;
    localparam int RHS_W   = V2_W + FSQ_W;
    localparam int LHS_W   = S_W + FSQ_W;
    localparam int BYTE_W  = 8;

    localparam logic [RHS_W-1:0] Y_RHS = RHS_W'(64'(FULL_SQ) * 64'(Y_SQ));

    typedef struct packed {
        logic              neg;
        logic [RHS_W-1:0]  rhs;
        logic [BYTE_W-1:0] b;
    } lane_t;

    typedef struct packed {
        logic           valid;
        logic [S_W-1:0] s;
        lane_t          z;
        lane_t          y;
        lane_t          x;
    } work_t;

    // Tries one more bit of the byte: keeps it when (2t-255)*sqrt(s) <= 255*v,
    // decided on squares and signs.
    function automatic lane_t decide_bit(lane_t ln, logic [S_W-1:0] s, logic [2:0] bit_sel);
        logic [BYTE_W-1:0] t;
        logic [BYTE_W:0]   two_t;
        logic [BYTE_W-1:0] aa;
        logic [FSQ_W-1:0]  aa_sq;
        logic [LHS_W-1:0]  lhs;
        logic [LHS_W-1:0]  rhs;
        logic              take;
        lane_t             res;
        t     = ln.b | (BYTE_W'(1) << bit_sel);
        two_t = {t, 1'b0};
        aa    = t[BYTE_W-1] ? BYTE_W'(two_t - 9'd255) : BYTE_W'(9'd255 - two_t);
        aa_sq = FSQ_W'(aa) * FSQ_W'(aa);
        lhs   = LHS_W'(aa_sq) * LHS_W'(s);
        rhs   = LHS_W'(ln.rhs);
        if (t[BYTE_W-1])
        begin
            take = !ln.neg && (lhs <= rhs);
        end
        else
        begin
            take = !ln.neg || (lhs >= rhs);
        end
        res   = ln;
        res.b = take ? t : ln.b;
        return res;
    endfunction

endpackage

// ===== hdl/hnm_height_mem.sv =====
// Height store: one write port and two registered read ports.
// Depends on hnm_pkg for address and sample widths.
module hnm_height_mem (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [hnm_pkg::ADDR_W-1:0]           wr_addr,
    input  logic signed [hnm_pkg::HEIGHT_BITS-1:0] wr_data,
    input  logic                                 rd_en,
    input  logic [hnm_pkg::ADDR_W-1:0]           rd_addr_a,
    input  logic [hnm_pkg::ADDR_W-1:0]           rd_addr_b,
    output logic signed [hnm_pkg::HEIGHT_BITS-1:0] rd_a,
    output logic signed [hnm_pkg::HEIGHT_BITS-1:0] rd_b
);

    logic signed [hnm_pkg::HEIGHT_BITS-1:0] mem [hnm_pkg::CELLS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a <= mem[rd_addr_a];
            rd_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== hdl/hnm_diff_sq.sv =====
// Front of the arithmetic pipeline: neighbour differences, squares, the
// sum of squares and the scaled right-hand sides. Depends on hnm_pkg.
module hnm_diff_sq (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   second,
    input  logic signed [hnm_pkg::HEIGHT_BITS-1:0] rd_a,
    input  logic signed [hnm_pkg::HEIGHT_BITS-1:0] rd_b,
    output hnm_pkg::work_t                         work
);

    localparam int HB = hnm_pkg::HEIGHT_BITS;

    logic [HB:0]               diff;
    logic [HB:0]               diff_abs;
    logic                      v1_reg, v2_reg, v3_reg;
    logic                      dxn_reg, dxn2_reg, dzn_reg, dxn3_reg, dzn3_reg;
    logic [hnm_pkg::MAG_W-1:0] dxm_reg, dxm2_reg, dzm_reg;
    logic [hnm_pkg::SQ_W-1:0]  dxsq_reg, dzsq_reg;
    hnm_pkg::work_t            work_reg;

    // The read ports hold left/right first, then up/down.
    assign diff     = {rd_a[HB-1], rd_a} - {rd_b[HB-1], rd_b};
    assign diff_abs = diff[HB] ? (~diff + 1'b1) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            work_reg <= '0;
        end
        else if (en)
        begin
            v1_reg         <= second;
            v2_reg         <= v1_reg;
            v3_reg         <= v2_reg;
            work_reg.valid <= v3_reg;
            work_reg.s     <= hnm_pkg::S_W'(dxsq_reg) + hnm_pkg::S_W'(dzsq_reg)
                              + hnm_pkg::S_W'(hnm_pkg::Y_SQ);
            work_reg.x.neg <= dxn3_reg;
            work_reg.x.rhs <= hnm_pkg::RHS_W'(hnm_pkg::FULL_SQ) * hnm_pkg::RHS_W'(dxsq_reg);
            work_reg.x.b   <= '0;
            work_reg.z.neg <= dzn3_reg;
            work_reg.z.rhs <= hnm_pkg::RHS_W'(hnm_pkg::FULL_SQ) * hnm_pkg::RHS_W'(dzsq_reg);
            work_reg.z.b   <= '0;
            work_reg.y.neg <= 1'b0;
            work_reg.y.rhs <= hnm_pkg::Y_RHS;
            work_reg.y.b   <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxn_reg  <= diff[HB];
            dxm_reg  <= diff_abs[HB-1:0];
            dxn2_reg <= dxn_reg;
            dxm2_reg <= dxm_reg;
            dzn_reg  <= diff[HB];
            dzm_reg  <= diff_abs[HB-1:0];
            dxn3_reg <= dxn2_reg;
            dzn3_reg <= dzn_reg;
            dxsq_reg <= hnm_pkg::SQ_W'(dxm2_reg) * hnm_pkg::SQ_W'(dxm2_reg);
            dzsq_reg <= hnm_pkg::SQ_W'(dzm_reg) * hnm_pkg::SQ_W'(dzm_reg);
        end
    end

    assign work = work_reg;

endmodule

// ===== hdl/hnm_byte_stage.sv =====
// One bit of the byte search for all three components, one register stage.
// Depends on hnm_pkg for the word type and the bit decision.
module hnm_byte_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [2:0]     bit_sel,
    input  hnm_pkg::work_t work_in,
    output hnm_pkg::work_t work_out
);

    hnm_pkg::work_t work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
        end
        else if (en)
        begin
            work_reg.valid <= work_in.valid;
            work_reg.s     <= work_in.s;
            work_reg.z     <= hnm_pkg::decide_bit(work_in.z, work_in.s, bit_sel);
            work_reg.y     <= hnm_pkg::decide_bit(work_in.y, work_in.s, bit_sel);
            work_reg.x     <= hnm_pkg::decide_bit(work_in.x, work_in.s, bit_sel);
        end
    end

    assign work_out = work_reg;

endmodule

// ===== hdl/heightmap_normal_map.sv =====
// A write word does not hold off the input; a compute word holds it off while its
// second pair of reads is issued, because its four neighbour reads share the two
// read ports of the height store.
// Reset: rst_n clears all valid and phase state at once; the height store is not
// cleared and a cell reads as garbage until written.
module heightmap_normal_map (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [5:0]  col,
    input  logic [5:0]  row,
    input  logic signed [15:0] height,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_z,
    output logic [7:0]  byte_y,
    output logic [7:0]  byte_x
);

    localparam int CW = hnm_pkg::COORD_W;

    // The whole pipeline advances together; it stops only when a result waits
    // in the output register and the consumer is not taking it.
    logic en;
    logic accept;
    logic phase_reg, phase_next;
    logic [CW-1:0] col_reg, row_reg;
    logic [CW-1:0] c_in, r_in;
    logic [hnm_pkg::ADDR_W-1:0] addr_a, addr_b;
    logic signed [hnm_pkg::HEIGHT_BITS-1:0] rd_a, rd_b;
    hnm_pkg::work_t stage_w [0:8];
    logic out_valid_reg;
    logic [7:0] z_reg, y_reg, x_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en && !phase_reg;
    assign accept   = in_valid && in_ready;
    assign c_in     = col[CW-1:0];
    assign r_in     = row[CW-1:0];

    // A compute word reads left and right at its acceptance edge, then up and
    // down while phase_reg is set, while the input is held off.
    always_comb
    begin
        if (phase_reg)
        begin
            addr_a = {row_reg - 1'b1, col_reg};
            addr_b = {row_reg + 1'b1, col_reg};
        end
        else
        begin
            addr_a = {r_in, c_in - 1'b1};
            addr_b = {r_in, c_in + 1'b1};
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (en)
        begin
            phase_next = accept && command;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= c_in;
            row_reg <= r_in;
        end
    end

    hnm_height_mem u_mem (
        .clk       (clk),
        .wr_en     (accept && !command),
        .wr_addr   ({r_in, c_in}),
        .wr_data   (hnm_pkg::HEIGHT_BITS'(height)),
        .rd_en     (en),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_a      (rd_a),
        .rd_b      (rd_b)
    );

    hnm_diff_sq u_diff (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .second (phase_reg),
        .rd_a   (rd_a),
        .rd_b   (rd_b),
        .work   (stage_w[0])
    );

    // Eight stages, most significant bit of the byte first.
    for (genvar i = 0; i < 8; i++)
    begin : g_bit
        hnm_byte_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .bit_sel  (3'(7 - i)),
            .work_in  (stage_w[i]),
            .work_out (stage_w[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stage_w[8].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg <= stage_w[8].z.b;
            y_reg <= stage_w[8].y.b;
            x_reg <= stage_w[8].x.b;
        end
    end

    assign out_valid = out_valid_reg;
    assign byte_z    = z_reg;
    assign byte_y    = y_reg;
    assign byte_x    = x_reg;

    // The input must be held off while the second pair of reads is issued.
    a_phase_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !in_ready)
        else $error("input accepted during second read phase");

    // An accepted compute word always enters its second read phase.
    a_compute_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command) |=> phase_reg)
        else $error("compute word skipped its second read phase");

    // A stall freezes the read sequencer.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(phase_reg))
        else $error("read phase moved during a stall");

endmodule
